// ----- rtl/b64d_pkg.sv -----
`default_nettype none

package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [5:0] SEXTET_62  = 6'd62;
  localparam logic [5:0] SEXTET_63  = 6'd63;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  // one unit of work for the back end: up to three bytes, then an optional status
  typedef struct packed {
    logic [1:0]  nbytes;
    logic [23:0] word;
    logic        has_status;
    logic [1:0]  status;
  } b64d_job_t;

  // {in_alphabet, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
      return {1'b1, v[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
      return {1'b1, v[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
      return {1'b1, v[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, SEXTET_62};
    end else if (c == 8'h2F) begin
      return {1'b1, SEXTET_63};
    end
    return 7'd0;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/b64d_front.sv -----
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_terminator,
  input  wire logic        q_full,
  output logic             q_push,
  output b64d_job_t        q_job
);

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        any_r, any_nxt;
  logic        disc_r, disc_nxt;
  logic        accept;
  logic [6:0]  lookup;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign lookup   = sextet_of(in_symbol);

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    any_nxt  = any_r;
    disc_nxt = disc_r;
    q_push   = 1'b0;
    q_job    = '0;
    if (accept) begin
      if (in_terminator) begin
        if (!disc_r) begin
          q_push           = 1'b1;
          q_job.has_status = 1'b1;
          case (cnt_r)
            2'd2: begin
              q_job.nbytes = 2'd1;
              q_job.word   = {acc_r[11:4], 16'h0000};
            end
            2'd3: begin
              q_job.nbytes = 2'd2;
              q_job.word   = {acc_r[17:10], acc_r[9:2], 8'h00};
            end
            default: begin
              q_job.nbytes = 2'd0;
            end
          endcase
          q_job.status = (any_r || cnt_r[1]) ? STAT_OK : STAT_EMPTY;
        end
        acc_nxt  = '0;
        cnt_nxt  = '0;
        any_nxt  = 1'b0;
        disc_nxt = 1'b0;
      end else if (!disc_r && in_symbol != PAD_CHAR) begin
        if (!lookup[6]) begin
          disc_nxt         = 1'b1;
          q_push           = 1'b1;
          q_job.has_status = 1'b1;
          q_job.status     = STAT_INVALID;
        end else begin
          acc_nxt = {acc_r[17:0], lookup[5:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            any_nxt      = 1'b1;
            q_push       = 1'b1;
            q_job.nbytes = 2'd3;
            q_job.word   = {acc_r[17:0], lookup[5:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      any_r  <= 1'b0;
      disc_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      any_r  <= any_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64d_queue.sv -----
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire b64d_job_t push_job,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output b64d_job_t      head_job
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_job_t       store_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign head_job  = store_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64d_back.sv -----
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_not_empty,
  input  wire b64d_job_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic            out_byte_valid,
  output logic [1:0]      out_status,
  output logic            out_last
);

  b64d_job_t  cur_r;
  logic       cur_valid_r;
  logic [1:0] pos_r;
  logic       out_valid_r;
  logic [7:0] data_r;
  logic       bv_r;
  logic [1:0] status_r;
  logic       last_r;

  logic       out_load;
  logic       is_byte;
  logic       final_piece;
  logic [7:0] byte_sel;

  assign is_byte     = (pos_r < cur_r.nbytes);
  assign final_piece = cur_r.has_status ? !is_byte : (pos_r == cur_r.nbytes - 2'd1);
  assign out_load    = cur_valid_r && (!out_valid_r || out_ready);
  assign q_pop       = q_not_empty && (!cur_valid_r || (out_load && final_piece));

  always_comb begin
    case (pos_r)
      2'd0:    byte_sel = cur_r.word[23:16];
      2'd1:    byte_sel = cur_r.word[15:8];
      default: byte_sel = cur_r.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_r       <= q_head;
        cur_valid_r <= 1'b1;
        pos_r       <= '0;
      end else if (out_load) begin
        if (final_piece) begin
          cur_valid_r <= 1'b0;
          pos_r       <= '0;
        end else begin
          pos_r <= pos_r + 2'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      data_r   <= is_byte ? (byte_sel & BYTE_MASK) : 8'h00;
      bv_r     <= is_byte;
      status_r <= is_byte ? STAT_OK : cur_r.status;
      last_r   <= !is_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = data_r;
  assign out_byte_valid = bv_r;
  assign out_status     = status_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// ----- rtl/base64_stream_decoder.sv -----
`default_nettype none

// Base64 (standard alphabet) stream decoder. One character per input
// transaction, or a terminator. Each group of four characters gives three
// byte results, most significant first; '=' is skipped anywhere. At the
// terminator a two- or three-character tail gives one or two bytes, then a
// status result with last set closes the string: ok, or empty when no byte
// came out. A character outside the alphabet gives an invalid status with
// last set at once, and everything up to the next terminator is dropped
// (that terminator gives nothing). The front end takes one input
// transaction per clock while the job queue (QueueDepth entries) has room;
// the back end sends one result per clock while the receiver takes results, so
// the sustained input rate follows the output rate. The first result of an
// item reaches the output at the earliest through the queue write, then the
// job load, then the output register, and later while the back end is still
// busy with earlier jobs.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_terminator,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic            out_byte_valid,
  output logic [1:0]      out_status,
  output logic            out_last
);

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  b64d_job_t q_job;
  b64d_job_t q_head;

  b64d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol     (in_symbol),
    .in_terminator (in_terminator),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  // front never writes a job into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job pushed into full queue");

  a_byte_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> !out_last && out_status == STAT_OK)
    else $error("byte result carries status or last");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && out_status != 2'd3)
    else $error("status result malformed");

endmodule

`default_nettype wire

// ----- bench/base64_stream_decoder_test.sv -----
module base64_stream_decoder_test;
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last;
  } out_rec_t;

  // Tracks decoder state and holds the results still owed by the block.
  class b64_decode_ledger;
    out_rec_t    owed[$];
    logic [23:0] acc;
    logic [1:0]  count;
    bit          any_bytes;
    bit          discarding;
    int          errors;
    int          n_bytes;
    int          n_ok;
    int          n_invalid;
    int          n_empty;

    function new();
      clear();
      errors = 0;
      n_bytes = 0;
      n_ok = 0;
      n_invalid = 0;
      n_empty = 0;
    endfunction

    function void clear();
      acc = '0;
      count = '0;
      any_bytes = 0;
      discarding = 0;
    endfunction

    function bit sextet_lookup(input logic [7:0] c, output logic [5:0] v);
      v = '0;
      if (c >= "A" && c <= "Z") v = 6'(c - "A");
      else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
      else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
      else if (c == "+") v = 6'd62;
      else if (c == "/") v = 6'd63;
      else return 0;
      return 1;
    endfunction

    function void owe_byte(input logic [7:0] b);
      owed.push_back('{data_byte: b, byte_valid: 1'b1, status: STAT_OK, last: 1'b0});
    endfunction

    function void owe_status(input logic [1:0] st);
      owed.push_back('{data_byte: 8'h00, byte_valid: 1'b0, status: st, last: 1'b1});
    endfunction

    // called for every accepted input transaction
    function void take_symbol(input logic [7:0] sym, input logic term);
      logic [5:0] v;
      if (term) begin
        if (!discarding) begin
          if (count == 2'd2) begin
            owe_byte(acc[11:4]);
            any_bytes = 1;
          end else if (count == 2'd3) begin
            owe_byte(acc[17:10]);
            owe_byte(acc[9:2]);
            any_bytes = 1;
          end
          owe_status(any_bytes ? STAT_OK : STAT_EMPTY);
        end
        clear();
        return;
      end
      if (discarding || sym == PAD_CHAR) return;
      if (!sextet_lookup(sym, v)) begin
        discarding = 1;
        owe_status(STAT_INVALID);
        return;
      end
      acc = {acc[17:0], v};
      count = count + 2'd1;
      if (count == 2'd0) begin
        owe_byte(acc[23:16]);
        owe_byte(acc[15:8]);
        owe_byte(acc[7:0]);
        any_bytes = 1;
      end
    endfunction

    function void match_output(input out_rec_t got);
      out_rec_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: data_byte %0h byte_valid %0b status %0d last %0b",
               got.data_byte, got.byte_valid, got.status, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (want.byte_valid) n_bytes++;
      else if (want.status == STAT_OK) n_ok++;
      else if (want.status == STAT_INVALID) n_invalid++;
      else n_empty++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_symbol = 8'h00;
  logic       in_terminator = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic [1:0] out_status;
  logic       out_last;

  b64_decode_ledger ledger = new();
  int  total_accepted = 0;
  int  burst_left = 0;
  bit  long_hold_done = 0;

  base64_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_terminator  (in_terminator),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) ledger.take_symbol(in_symbol, in_terminator);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      ledger.match_output('{data_byte: out_data_byte, byte_valid: out_byte_valid,
                            status: out_status, last: out_last});
  end

  // receiver: per-phase stall mask, plus one long hold-off to back the block up
  initial begin : receiver
    logic [15:0] ready_mask;
    int          phase;
    ready_mask = '1;
    phase = 0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && total_accepted >= 60) begin
        out_ready <= 1'b0;
        repeat (120) @(negedge clk);
        long_hold_done = 1;
      end else begin
        if (phase == 0) begin
          case ($urandom_range(0, 3))
            0: ready_mask = '1;
            1: ready_mask = 16'($urandom) | 16'h0001;
            2: ready_mask = 16'($urandom) & 16'($urandom) | 16'h8000;
            default: ready_mask = 16'($urandom) | 16'($urandom);
          endcase
        end
        out_ready <= ready_mask[phase];
        phase = (phase + 1) % 16;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("[base64_stream_decoder] ERROR");
    $finish;
  end

  // holds the channel until the transaction goes through; returns at a falling edge
  task automatic send_item(input logic [7:0] sym, input logic term);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_terminator <= term;
    do @(posedge clk); while (!in_ready);
    total_accepted++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] char_of(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] pick_invalid();
    logic [7:0] c;
    logic [5:0] v;
    do c = 8'($urandom); while (ledger.sextet_lookup(c, v) || c == PAD_CHAR);
    return c;
  endfunction

  initial begin : stimulus
    int strings;
    int len;
    int bad_at;
    bit dropping;
    strings = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // terminator alone with a nonzero symbol: empty close
    send_item(8'hFF, 1'b1);
    send_text("+/09");
    send_text("aZ=");
    send_text("zAy");
    send_text("Q");
    // invalid mid-string, then junk that must be dropped
    send_item("B", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("A", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b1);
    send_text("=");

    while (total_accepted < 130) begin
      strings++;
      if ($urandom_range(0, 5) == 0) begin
        // raw noise, any byte value
        repeat ($urandom_range(1, 5)) begin
          send_item(8'($urandom), 1'b0);
        end
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
        bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : -1;
        dropping = 0;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(PAD_CHAR, 1'b0);
          end else if (dropping) begin
            send_item(8'($urandom), 1'b0);
          end else if (i == bad_at) begin
            send_item(pick_invalid(), 1'b0);
            dropping = 1;
          end else begin
            send_item(char_of($urandom_range(0, 63)), 1'b0);
          end
        end
      end
      send_item(8'($urandom), 1'b1);
    end
    in_valid <= 1'b0;

    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("%0d input transactions over %0d random strings; %0d bytes decoded",
             total_accepted, strings, ledger.n_bytes);
    $display("closing statuses: %0d ok, %0d invalid, %0d empty",
             ledger.n_ok, ledger.n_invalid, ledger.n_empty);
    if (ledger.errors == 0) begin
      $display("[base64_stream_decoder] OK");
    end else begin
      $display("[base64_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule
